### sv/assert_macros.svh
// Assertion helpers shared by rfp_divider and rfp_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

### sv/rfp_pkg.sv
`default_nettype none

package rfp_pkg;

   localparam int BYTES_W          = 13;
   localparam int HDR_W            = 7;
   localparam int BLOCK_W          = 16;
   localparam int SEQ_W            = 16;
   localparam int PART_W           = BYTES_W + 1;
   localparam int MAX_PACKET_BYTES = 8192;
   localparam int MIN_BLOCK_SIZE   = 200;
   localparam int BLOCK_SIZE_RESET = 1400;
   localparam int MAX_RESULTS      = 64;
   localparam int RES_CNT_W        = 6;
   localparam int DIV_STEPS        = BYTES_W;
   localparam int DIV_CNT_W        = 4;

   // FU position codes
   localparam logic [1:0] POS_START  = 2'd0;
   localparam logic [1:0] POS_MIDDLE = 2'd1;
   localparam logic [1:0] POS_END    = 2'd2;

   // Codec codes
   localparam logic [1:0] CODEC_H264 = 2'd0;
   localparam logic [1:0] CODEC_H265 = 2'd1;

   typedef struct packed {
      logic [BYTES_W-1:0] packet_size;
      logic [HDR_W-1:0]   header_size;
      logic [BYTES_W-1:0] payload_length;
      logic [1:0]         codec;
      logic               is_fu_unit;
      logic [1:0]         fu_position_in;
   } req_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   sequence_number;
      logic [BYTES_W-1:0] byte_offset;
      logic [BYTES_W-1:0] data_length;
      logic               is_fragment;
      logic [1:0]         fu_position_out;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [BYTES_W-1:0] dividend;
      logic [BLOCK_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [BYTES_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_PARTS,
      ST_DIV_SIZE,
      ST_EMIT
   } state_type;

   // Clamp a byte count to MAX_PACKET_BYTES - 1
   function automatic logic [BYTES_W-1:0] sat_bytes(input logic [BYTES_W-1:0] v);
      logic [BYTES_W:0] top;
      top = (BYTES_W+1)'(MAX_PACKET_BYTES - 1);
      if ({1'b0, v} > top) begin
         return top[BYTES_W-1:0];
      end
      return v;
   endfunction

endpackage

`default_nettype wire

### sv/rfp_divider.sv
`default_nettype none
`include "assert_macros.svh"

module rfp_divider
   import rfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BLOCK_W-1:0]   rem_ff, rem_in;
   logic [BYTES_W-1:0]   quo_ff, quo_in;
   logic [BLOCK_W-1:0]   divisor_ff, divisor_in;

   logic [BLOCK_W:0]     trial;
   logic                 ge;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[BYTES_W-1]};
      ge    = trial >= {1'b0, divisor_ff};
   end

   always_comb begin
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_W'(DIV_STEPS - 1);
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? BLOCK_W'(trial - {1'b0, divisor_ff}) : trial[BLOCK_W-1:0];
         quo_in = {quo_ff[BYTES_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   `ASSERT_NEVER(a_start_while_busy, clock, reset, div_req.start && busy_ff)
   `ASSERT_NEVER(a_done_while_busy, clock, reset, done_ff && busy_ff)
   `ASSERT_PROP(a_done_after_last_step, clock, reset,
      (busy_ff && cnt_ff == '0 && !div_req.start) |=> done_ff)
   `ASSERT_PROP(a_zero_divisor, clock, reset,
      div_req.start |-> (div_req.divisor != '0))

endmodule

`default_nettype wire

### sv/rfp_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module rfp_ctrl
   import rfp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [BLOCK_W-1:0] block_size,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   input  wire logic               out_free,
   output logic                    emit_valid,
   output rsp_type                 emit_data,
   output div_req_type             div_req,
   input  wire div_rsp_type        div_rsp
);

   state_type            state_ff, state_in;
   logic [BYTES_W-1:0]   psz_ff, psz_in;
   logic [HDR_W-1:0]     hdr_ff, hdr_in;
   logic [BYTES_W-1:0]   pay_ff, pay_in;
   logic [1:0]           src_ff, src_in;
   logic                 split_ff, split_in;
   logic [BYTES_W-1:0]   off_ff, off_in;
   logic [PART_W-1:0]    part_ff, part_in;
   logic [RES_CNT_W-1:0] n_ff, n_in;
   logic [SEQ_W-1:0]     seq_ff, seq_in;

   logic                 accept;
   logic [BYTES_W-1:0]   psz_w;
   logic [BYTES_W-1:0]   pay_w;
   logic [1:0]           src_w;
   logic                 split_w;
   logic                 split_go;
   logic [BLOCK_W-1:0]   opt_w;
   logic [PART_W-1:0]    quo_plus;
   logic [BYTES_W-1:0]   rem_len;
   logic                 reach_end;
   logic [BYTES_W-1:0]   len_w;
   logic [1:0]           pos_w;
   logic                 last_w;
   logic                 do_emit;

   // Decode the incoming request
   always_comb begin
      accept   = (state_ff == ST_IDLE) && req_valid;
      psz_w    = sat_bytes(req_data.packet_size);
      pay_w    = sat_bytes(req_data.payload_length);
      src_w    = (req_data.fu_position_in == POS_START ||
                  req_data.fu_position_in == POS_END) ? req_data.fu_position_in : POS_MIDDLE;
      split_w  = ({3'b0, psz_w} > block_size) && req_data.is_fu_unit &&
                 (req_data.codec == CODEC_H264 || req_data.codec == CODEC_H265);
      split_go = split_w && ({6'b0, req_data.header_size} < psz_w);
      opt_w    = block_size - {9'b0, req_data.header_size};
      quo_plus = {1'b0, div_rsp.quotient} + PART_W'(1);
   end

   // Slice arithmetic for the current fragment
   always_comb begin
      rem_len   = psz_ff - off_ff;
      reach_end = part_ff >= {1'b0, rem_len};
      len_w     = reach_end ? rem_len : part_ff[BYTES_W-1:0];
      if (off_ff == {6'b0, hdr_ff} && src_ff == POS_START) begin
         pos_w = POS_START;
      end else if (reach_end && src_ff == POS_END) begin
         pos_w = POS_END;
      end else begin
         pos_w = POS_MIDDLE;
      end
      last_w  = reach_end || (n_ff == RES_CNT_W'(MAX_RESULTS - 1));
      do_emit = (state_ff == ST_EMIT) && out_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && psz_w != '0) begin
               if (!split_w) begin
                  state_in = ST_EMIT;
               end else if (split_go) begin
                  state_in = ST_DIV_PARTS;
               end
            end
         end
         ST_DIV_PARTS: begin
            if (div_rsp.done) begin
               state_in = ST_DIV_SIZE;
            end
         end
         ST_DIV_SIZE: begin
            if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (do_emit && (!split_ff || last_w)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake, divider requests and the descriptor
   always_comb begin
      req_stall        = (state_ff != ST_IDLE);
      div_req.start    = 1'b0;
      div_req.dividend = pay_w;
      div_req.divisor  = opt_w;
      case (state_ff)
         ST_IDLE: begin
            div_req.start = accept && split_go;
         end
         ST_DIV_PARTS: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = pay_ff;
            div_req.divisor  = {2'b0, quo_plus};
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
      emit_valid                = do_emit;
      emit_data.sequence_number = seq_ff + SEQ_W'(1);
      if (split_ff) begin
         emit_data.byte_offset     = off_ff;
         emit_data.data_length     = len_w;
         emit_data.is_fragment     = 1'b1;
         emit_data.fu_position_out = pos_w;
         emit_data.last            = last_w;
      end else begin
         emit_data.byte_offset     = '0;
         emit_data.data_length     = psz_ff;
         emit_data.is_fragment     = 1'b0;
         emit_data.fu_position_out = src_ff;
         emit_data.last            = 1'b1;
      end
   end

   // Datapath register updates
   always_comb begin
      psz_in   = psz_ff;
      hdr_in   = hdr_ff;
      pay_in   = pay_ff;
      src_in   = src_ff;
      split_in = split_ff;
      off_in   = off_ff;
      part_in  = part_ff;
      n_in     = n_ff;
      seq_in   = seq_ff;
      if (accept) begin
         psz_in   = psz_w;
         hdr_in   = req_data.header_size;
         pay_in   = pay_w;
         src_in   = src_w;
         split_in = split_w;
      end
      if (state_ff == ST_DIV_SIZE && div_rsp.done) begin
         part_in = quo_plus;
         off_in  = {6'b0, hdr_ff};
         n_in    = '0;
      end
      if (do_emit) begin
         seq_in = seq_ff + SEQ_W'(1);
         off_in = off_ff + len_w;
         n_in   = n_ff + RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
      end
      psz_ff   <= psz_in;
      hdr_ff   <= hdr_in;
      pay_ff   <= pay_in;
      src_ff   <= src_in;
      split_ff <= split_in;
      off_ff   <= off_in;
      part_ff  <= part_in;
      n_ff     <= n_in;
   end

   `ASSERT_PROP(a_done_only_when_waiting, clock, reset,
      div_rsp.done |-> (state_ff == ST_DIV_PARTS || state_ff == ST_DIV_SIZE))
   `ASSERT_PROP(a_slice_inside_packet, clock, reset,
      (state_ff == ST_EMIT && split_ff) |-> (off_ff < psz_ff && part_ff != '0))
   `ASSERT_PROP(a_seq_advances, clock, reset,
      do_emit |=> (seq_ff == $past(seq_ff) + SEQ_W'(1)))
   `ASSERT_PROP(a_emit_needs_room, clock, reset, emit_valid |-> out_free)

endmodule

`default_nettype wire

### sv/rtp_fu_refragment_planner.sv
// RTP FU re-fragmentation planner.
// Requests arrive on req_valid/req_stall/req_data, one packet descriptor each.
// Each non-empty packet, but for the case below, yields one or more datagram
// descriptors on rsp_valid/rsp_stall/rsp_data; the last one of a packet
// carries last = 1. An H.264/H.265 FU packet larger than block_size is split
// into slices of equal size (last slice clamped), at most 64 per packet, but
// yields none if its header_size is not below its size; others go out whole.
// block_size is written through csr_valid/csr_ready/csr_data; the user must
// write it only while idle, which the block itself does not enforce;
// csr_ready is always high and writes below 200 store 200. A split packet
// runs two 13-step divisions on the shared serial divider and then emits its
// fragments, one fragment per cycle while rsp is not stalled. req_stall is
// high from acceptance until the last descriptor of the packet has entered
// the output register. A stalled rsp holds its descriptor, and fragment
// emission waits. Reset (synchronous) clears the sequence counter to zero
// (the first datagram carries 1) and sets block_size to 1400.
`default_nettype none

module rtp_fu_refragment_planner
   import rfp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [BLOCK_W-1:0] csr_data
);

   logic [BLOCK_W-1:0] block_size_ff, block_size_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               emit_valid;
   rsp_type            emit_data;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // Raise small block sizes to the floor
   always_comb begin
      csr_ready     = 1'b1;
      block_size_in = block_size_ff;
      if (csr_valid) begin
         block_size_in = (csr_data < BLOCK_W'(MIN_BLOCK_SIZE)) ?
                         BLOCK_W'(MIN_BLOCK_SIZE) : csr_data;
      end
   end

   // Output register: load on emit, drop once taken
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLOCK_W'(BLOCK_SIZE_RESET);
         rsp_valid_ff  <= 1'b0;
      end else begin
         block_size_ff <= block_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .block_size (block_size_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit_data  (emit_data),
      .div_req    (div_req),
      .div_rsp    (div_rsp)
   );

   rfp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

`default_nettype wire
